// ===== sv/qmn_pkg.sv =====
// shared types, constants and product term tables for the quaternion multiply-normalize block
`default_nettype none

package qmn_pkg;

    localparam int FRAC_BITS_DEF = 29;

    // widths fixed by the 32-bit input components
    localparam int PROD_W = 64;   // one component product
    localparam int SUM_W  = 67;   // signed sum of four products
    localparam int MAG_W  = 65;   // magnitude of a product component
    localparam int SQ_W   = 129;  // square of a magnitude
    localparam int PAIR_W = 130;  // sum of two squares
    localparam int NORM_W = 131;  // squared norm

    // index of the scalar component
    localparam logic [1:0] COMP_W = 2'd3;

    // lane i, term t multiplies a[t] by b[TERM_B[i][t]]
    localparam logic [1:0] TERM_B [4][4] = '{
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd0, 2'd1, 2'd2, 2'd3}
    };

    // bit t set when term t of lane i is subtracted
    localparam logic [3:0] TERM_NEG [4] = '{4'b0100, 4'b0001, 4'b0010, 4'b0111};

    typedef struct packed {
        logic               func;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] a_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] b_w;
    } qmn_in_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic        [29:0] r_w;
        logic               degenerate;
    } qmn_out_t;

endpackage

`default_nettype wire

// ===== sv/qmn_front.sv =====
// product, squared norm and rounding targets of the quaternion pipeline
`default_nettype none

module qmn_front #(
    parameter int FRAC_BITS = qmn_pkg::FRAC_BITS_DEF,
    localparam int RW = 2 * FRAC_BITS + 140
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire qmn_pkg::qmn_in_t                in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [RW-1:0]                        out_tgt [4],
    output logic [qmn_pkg::NORM_W-1:0]           out_norm,
    output logic [3:0]                           out_sgn,
    output logic                                 out_deg
);

    localparam int NS = 7;

    logic [NS:1] vld_reg;
    logic [NS:1] adv;

    logic signed [31:0] a_arr [4];
    logic signed [31:0] b_arr [4];

    logic signed [qmn_pkg::PROD_W-1:0] prod_reg  [4][4];
    logic signed [qmn_pkg::PROD_W-1:0] prod_next [4][4];
    logic signed [qmn_pkg::SUM_W-1:0]  p_reg  [4];
    logic signed [qmn_pkg::SUM_W-1:0]  p_next [4];
    logic [qmn_pkg::MAG_W-1:0]         mag_reg  [4];
    logic [qmn_pkg::MAG_W-1:0]         mag_next [4];
    logic [63:0]                       hh_reg [4];
    logic [64:0]                       hl_reg [4];
    logic [65:0]                       ll_reg [4];
    logic [qmn_pkg::SQ_W-1:0]          sq_reg  [4];
    logic [qmn_pkg::SQ_W-1:0]          sq_next [4];
    logic [qmn_pkg::PAIR_W-1:0]        pair_reg [2];
    logic [RW-1:0]                     tgt6_reg  [4];
    logic [RW-1:0]                     tgt6_next [4];
    logic [RW-1:0]                     tgt7_reg  [4];
    logic [qmn_pkg::NORM_W-1:0]        norm_reg;

    logic [5:1] func_reg;
    logic [3:0] sgn_reg  [3:NS];
    logic [3:0] sgn_next;
    logic [NS:3] zero_reg;
    logic        zero_next;

    assign a_arr = '{in_data.a_x, in_data.a_y, in_data.a_z, in_data.a_w};
    assign b_arr = '{in_data.b_x, in_data.b_y, in_data.b_z, in_data.b_w};

    // a stage takes new data when it is empty or its contents move on
    always_comb begin
        adv[NS] = ~vld_reg[NS] | out_ready;
        for (int i = NS - 1; i >= 1; i--) begin
            adv[i] = ~vld_reg[i] | adv[i+1];
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = vld_reg[NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[1]) begin
                vld_reg[1] <= in_valid;
            end
            for (int i = 2; i <= NS; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int t = 0; t < 4; t++) begin
                prod_next[i][t] = a_arr[t] * b_arr[qmn_pkg::TERM_B[i][t]];
            end
        end
    end

    // conjugation flips the sign of every term that uses a vector part of b
    always_comb begin
        logic signed [qmn_pkg::SUM_W-1:0] term;
        logic signed [qmn_pkg::SUM_W-1:0] acc;
        for (int i = 0; i < 4; i++) begin
            acc = '0;
            for (int t = 0; t < 4; t++) begin
                term = qmn_pkg::SUM_W'(prod_reg[i][t]);
                if (qmn_pkg::TERM_NEG[i][t] ^
                    (func_reg[1] && (qmn_pkg::TERM_B[i][t] != qmn_pkg::COMP_W))) begin
                    term = -term;
                end
                acc = acc + term;
            end
            p_next[i] = acc;
        end
    end

    always_comb begin
        zero_next = 1'b1;
        for (int i = 0; i < 4; i++) begin
            mag_next[i] = p_reg[i][qmn_pkg::SUM_W-1] ? qmn_pkg::MAG_W'(-p_reg[i])
                                                     : qmn_pkg::MAG_W'(p_reg[i]);
            sgn_next[i] = p_reg[i][qmn_pkg::SUM_W-1] ^ p_reg[3][qmn_pkg::SUM_W-1];
            if (p_reg[i] != '0) begin
                zero_next = 1'b0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sq_next[i] = (qmn_pkg::SQ_W'(hh_reg[i]) << 66) + (qmn_pkg::SQ_W'(hl_reg[i]) << 34)
                       + qmn_pkg::SQ_W'(ll_reg[i]);
            // target scale 4 k^2 m^2 2^(2F), k = 2 on the vector part of a difference
            if (func_reg[5] && (i < 3)) begin
                tgt6_next[i] = RW'(sq_reg[i]) << (2 * FRAC_BITS + 4);
            end else begin
                tgt6_next[i] = RW'(sq_reg[i]) << (2 * FRAC_BITS + 2);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            prod_reg    <= prod_next;
            func_reg[1] <= in_data.func;
        end
        if (adv[2]) begin
            p_reg       <= p_next;
            func_reg[2] <= func_reg[1];
        end
        if (adv[3]) begin
            mag_reg     <= mag_next;
            sgn_reg[3]  <= sgn_next;
            zero_reg[3] <= zero_next;
            func_reg[3] <= func_reg[2];
        end
        if (adv[4]) begin
            for (int i = 0; i < 4; i++) begin
                hh_reg[i] <= mag_reg[i][64:33] * mag_reg[i][64:33];
                hl_reg[i] <= mag_reg[i][64:33] * mag_reg[i][32:0];
                ll_reg[i] <= mag_reg[i][32:0] * mag_reg[i][32:0];
            end
            sgn_reg[4]  <= sgn_reg[3];
            zero_reg[4] <= zero_reg[3];
            func_reg[4] <= func_reg[3];
        end
        if (adv[5]) begin
            sq_reg      <= sq_next;
            sgn_reg[5]  <= sgn_reg[4];
            zero_reg[5] <= zero_reg[4];
            func_reg[5] <= func_reg[4];
        end
        if (adv[6]) begin
            pair_reg[0] <= qmn_pkg::PAIR_W'(sq_reg[0]) + qmn_pkg::PAIR_W'(sq_reg[1]);
            pair_reg[1] <= qmn_pkg::PAIR_W'(sq_reg[2]) + qmn_pkg::PAIR_W'(sq_reg[3]);
            tgt6_reg    <= tgt6_next;
            sgn_reg[6]  <= sgn_reg[5];
            zero_reg[6] <= zero_reg[5];
        end
        if (adv[7]) begin
            norm_reg    <= qmn_pkg::NORM_W'(pair_reg[0]) + qmn_pkg::NORM_W'(pair_reg[1]);
            tgt7_reg    <= tgt6_reg;
            sgn_reg[7]  <= sgn_reg[6];
            zero_reg[7] <= zero_reg[6];
        end
    end

    assign out_tgt  = tgt7_reg;
    assign out_norm = norm_reg;
    assign out_sgn  = sgn_reg[NS];
    assign out_deg  = zero_reg[NS];

endmodule

`default_nettype wire

// ===== sv/qmn_round.sv =====
// digit-recurrence pipeline that rounds each component of the unit quaternion
`default_nettype none

module qmn_round #(
    parameter int FRAC_BITS = qmn_pkg::FRAC_BITS_DEF,
    localparam int RW = 2 * FRAC_BITS + 140
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [RW-1:0]                   in_tgt [4],
    input  wire logic [qmn_pkg::NORM_W-1:0]      in_norm,
    input  wire logic [3:0]                      in_sgn,
    input  wire logic                            in_deg,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output qmn_pkg::qmn_out_t                    out_data
);

    localparam int NR = FRAC_BITS + 2;           // one stage per result bit
    localparam int DW = FRAC_BITS + 2;           // result magnitude width
    localparam int OW = (DW > 32) ? DW : 32;

    logic [NR+1:0] vld_reg;
    logic [NR+1:0] adv;

    // residual T - d^2 N and running d N, with d = 2r - 1
    logic signed [RW-1:0]        res_reg [0:NR-1][4];
    logic signed [RW-1:0]        err_reg [0:NR-1][4];
    logic [qmn_pkg::NORM_W-1:0]  nrm_reg [0:NR-1];
    logic [DW-1:0]               r_reg   [0:NR][4];
    logic [3:0]                  sgn_reg [0:NR];
    logic [NR:0]                 deg_reg;

    qmn_pkg::qmn_out_t out_reg;
    qmn_pkg::qmn_out_t out_next;

    always_comb begin
        adv[NR+1] = ~vld_reg[NR+1] | out_ready;
        for (int i = NR; i >= 0; i--) begin
            adv[i] = ~vld_reg[i] | adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NR+1];
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i <= NR + 1; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int i = 0; i < 4; i++) begin
                res_reg[0][i] <= $signed(in_tgt[i]) - $signed(RW'(in_norm));
                err_reg[0][i] <= -$signed(RW'(in_norm));
                r_reg[0][i]   <= '0;
            end
            nrm_reg[0] <= in_norm;
            sgn_reg[0] <= in_sgn;
            deg_reg[0] <= in_deg;
        end
    end

    for (genvar j = 1; j <= NR; j++) begin : g_digit
        localparam int B = NR - j;

        logic signed [RW-1:0] trial [4];
        logic [3:0]           take;

        // try setting result bit B: d grows by 2^(B+1)
        always_comb begin
            for (int i = 0; i < 4; i++) begin
                trial[i] = res_reg[j-1][i] - (err_reg[j-1][i] <<< (B + 2))
                         - $signed(RW'(nrm_reg[j-1]) << (2 * B + 2));
                take[i]  = ~trial[i][RW-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[j]) begin
                for (int i = 0; i < 4; i++) begin
                    r_reg[j][i] <= r_reg[j-1][i] | (DW'(take[i]) << B);
                end
                sgn_reg[j] <= sgn_reg[j-1];
                deg_reg[j] <= deg_reg[j-1];
            end
        end

        if (j < NR) begin : g_carry
            always_ff @(posedge aclk) begin
                if (adv[j]) begin
                    for (int i = 0; i < 4; i++) begin
                        res_reg[j][i] <= take[i] ? trial[i] : res_reg[j-1][i];
                        err_reg[j][i] <= take[i]
                            ? err_reg[j-1][i] + $signed(RW'(nrm_reg[j-1]) << (B + 1))
                            : err_reg[j-1][i];
                    end
                    nrm_reg[j] <= nrm_reg[j-1];
                end
            end
        end
    end

    always_comb begin
        logic [OW-1:0] mag [4];
        logic [OW-1:0] val [4];
        for (int i = 0; i < 4; i++) begin
            mag[i] = OW'(r_reg[NR][i]);
            val[i] = sgn_reg[NR][i] ? -mag[i] : mag[i];
        end
        out_next.r_x        = val[0][31:0];
        out_next.r_y        = val[1][31:0];
        out_next.r_z        = val[2][31:0];
        out_next.r_w        = mag[3][29:0];
        out_next.degenerate = 1'b0;
        if (deg_reg[NR]) begin
            out_next            = '0;
            out_next.degenerate = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[NR+1]) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/quaternion_multiply_normalize.sv =====
// an accepted input passes through qmn_front and then qmn_round to the result
// throughput: one transaction per cycle; each stage holds while the next is full
// the rounding pipeline spends one stage per result bit, FRAC_BITS + 2 stages
// reset clears the valid bits of every stage; data registers are not reset
// a zero-norm product gives zero components with degenerate set
`default_nettype none

module quaternion_multiply_normalize #(
    parameter int FRAC_BITS = qmn_pkg::FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire qmn_pkg::qmn_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output qmn_pkg::qmn_out_t      m_data
);

    localparam int RW = 2 * FRAC_BITS + 140;

    logic                       mid_valid;
    logic                       mid_ready;
    logic [RW-1:0]              mid_tgt [4];
    logic [qmn_pkg::NORM_W-1:0] mid_norm;
    logic [3:0]                 mid_sgn;
    logic                       mid_deg;

    qmn_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_tgt   (mid_tgt),
        .out_norm  (mid_norm),
        .out_sgn   (mid_sgn),
        .out_deg   (mid_deg)
    );

    qmn_round #(
        .FRAC_BITS (FRAC_BITS)
    ) u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_tgt    (mid_tgt),
        .in_norm   (mid_norm),
        .in_sgn    (mid_sgn),
        .in_deg    (mid_deg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the quaternion multiply-normalize block
`default_nettype none

module tb;

    localparam int FRAC = qmn_pkg::FRAC_BITS_DEF;
    localparam int TAIL_CYCLES = FRAC + 30;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    qmn_pkg::qmn_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    qmn_pkg::qmn_out_t m_data;

    quaternion_multiply_normalize dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    qmn_pkg::qmn_in_t  pending_pairs[$];
    qmn_pkg::qmn_out_t expected_quats[$];
    int       sender_idle_pct = 0;
    int       receiver_stall_pct = 0;
    int       mismatches = 0;
    bit       pair_taken = 1'b0;

    // rounded k*|p|*2^F/sqrt(norm2): largest r with (2r-1)^2*norm2 <= 4k^2 p^2 2^2F
    function automatic logic [31:0] round_unit(input logic [255:0] mag,
                                               input logic [255:0] norm2,
                                               input int k);
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [255:0] d;
        logic [31:0]  r;
        logic [31:0]  c;
        rhs = ((mag * mag) * 256'(4 * k * k)) << (2 * FRAC);
        r = '0;
        for (int b = FRAC + 1; b >= 0; b--) begin
            c = r | (32'd1 << b);
            d = 256'(2 * longint'(c) - 1);
            lhs = d * d * norm2;
            if (lhs <= rhs) r = c;
        end
        return r;
    endfunction

    function automatic qmn_pkg::qmn_out_t unit_product(input qmn_pkg::qmn_in_t q);
        logic signed [127:0] a [4];
        logic signed [127:0] b [4];
        logic signed [127:0] p [4];
        logic [255:0]        mag [4];
        logic [255:0]        norm2;
        logic [31:0]         r;
        logic [31:0]         v;
        logic                flip;
        int                  k;
        qmn_pkg::qmn_out_t   o;
        a[0] = 128'(q.a_x); a[1] = 128'(q.a_y); a[2] = 128'(q.a_z); a[3] = 128'(q.a_w);
        b[0] = 128'(q.b_x); b[1] = 128'(q.b_y); b[2] = 128'(q.b_z); b[3] = 128'(q.b_w);
        // difference mode conjugates the second quaternion
        if (q.func) for (int i = 0; i < 3; i++) b[i] = -b[i];
        p[0] =  a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
        p[1] = -a[0]*b[2] + a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
        p[2] =  a[0]*b[1] - a[1]*b[0] + a[2]*b[3] + a[3]*b[2];
        p[3] = -a[0]*b[0] - a[1]*b[1] - a[2]*b[2] + a[3]*b[3];
        norm2 = '0;
        for (int i = 0; i < 4; i++) begin
            mag[i] = (p[i] < 0) ? 256'(-p[i]) : 256'(p[i]);
            norm2 = norm2 + mag[i] * mag[i];
        end
        o = '0;
        if (norm2 == 0) begin
            o.degenerate = 1'b1;
            return o;
        end
        flip = p[3] < 0;
        for (int i = 0; i < 4; i++) begin
            k = (q.func && i < 3) ? 2 : 1;
            r = round_unit(mag[i], norm2, k);
            v = ((p[i] < 0) != flip) ? -r : r;
            case (i)
                0: o.r_x = v;
                1: o.r_y = v;
                2: o.r_z = v;
                default: o.r_w = v[29:0];
            endcase
        end
        return o;
    endfunction

    // driver: update on the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || pair_taken) begin
                if (pending_pairs.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    s_data  <= pending_pairs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // monitor: sample on the rising edge
    always @(posedge aclk) begin
        qmn_pkg::qmn_out_t want;
        pair_taken = aresetn && s_valid && s_ready;
        if (pair_taken) expected_quats.push_back(unit_product(s_data));
        if (aresetn && m_valid && m_ready) begin
            if (expected_quats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %h", m_data);
            end else begin
                want = expected_quats.pop_front();
                if (m_data.r_x !== want.r_x || m_data.r_y !== want.r_y ||
                    m_data.r_z !== want.r_z || m_data.r_w !== want.r_w ||
                    m_data.degenerate !== want.degenerate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch x %h/%h y %h/%h z %h/%h w %h/%h deg %b/%b",
                                 want.r_x, m_data.r_x, want.r_y, m_data.r_y,
                                 want.r_z, m_data.r_z, want.r_w, m_data.r_w,
                                 want.degenerate, m_data.degenerate);
                end
            end
        end
    end

    function automatic qmn_pkg::qmn_in_t make_pair(input logic f,
                                          input logic [31:0] ax, ay, az, aw,
                                          input logic [31:0] bx, by, bz, bw);
        qmn_pkg::qmn_in_t q;
        q.func = f;
        q.a_x = ax; q.a_y = ay; q.a_z = az; q.a_w = aw;
        q.b_x = bx; q.b_y = by; q.b_z = bz; q.b_w = bw;
        return q;
    endfunction

    // component draw: mostly near unit scale, some full range, some zero
    function automatic logic [31:0] rand_comp();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return '0;
        if (sel <= 3) return $urandom;
        return 32'($signed($urandom_range(32'h4000_0000)) - 32'sh2000_0000);
    endfunction

    task automatic drain();
        wait (pending_pairs.size() == 0 && !s_valid && expected_quats.size() == 0);
        @(posedge aclk);
    endtask

    localparam logic [31:0] ONE  = 32'h2000_0000;
    localparam logic [31:0] MINV = 32'h8000_0000;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;

    initial begin
        qmn_pkg::qmn_in_t q;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed corners
        for (int f = 0; f < 2; f++) begin
            pending_pairs.push_back(make_pair(1'(f), 0, 0, 0, 0, 0, 0, 0, 0));
            pending_pairs.push_back(make_pair(1'(f), 0, 0, 0, ONE, 0, 0, 0, ONE));
            pending_pairs.push_back(make_pair(1'(f), MINV, MINV, MINV, MINV,
                                              MINV, MINV, MINV, MINV));
            pending_pairs.push_back(make_pair(1'(f), MAXV, MAXV, MAXV, MAXV,
                                              MINV, MAXV, MINV, MAXV));
            pending_pairs.push_back(make_pair(1'(f), ONE, 0, 0, 0, 0, 0, 0, ONE));
            pending_pairs.push_back(make_pair(1'(f), 0, 0, 0, -ONE, 0, 0, 0, ONE));
            pending_pairs.push_back(make_pair(1'(f), 32'hffff_ffff, 32'hffff_ffff, 1, 1,
                                              32'hffff_ffff, 1, 1, MINV));
            pending_pairs.push_back(make_pair(1'(f), 1, 0, 0, 0, 0, 1, 0, 0));
            pending_pairs.push_back(make_pair(1'(f), ONE, -ONE, ONE, ONE,
                                              ONE, -ONE, ONE, ONE));
            pending_pairs.push_back(make_pair(1'(f), 32'h1234_5678, 32'hdead_beef,
                                              32'h0bad_f00d, 32'hcafe_babe,
                                              32'h5555_5555, 32'haaaa_aaaa,
                                              32'h0f0f_0f0f, 32'hf0f0_f0f0));
        end
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
                default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
            endcase
            for (int n = 0; n < 235; n++) begin
                q.func = 1'($urandom_range(1));
                q.a_x = rand_comp(); q.a_y = rand_comp();
                q.a_z = rand_comp(); q.a_w = rand_comp();
                q.b_x = rand_comp(); q.b_y = rand_comp();
                q.b_z = rand_comp(); q.b_w = rand_comp();
                // same quaternion for both operands; in difference mode this gives zero rotation
                if ($urandom_range(19) == 0) begin
                    q.b_x = q.a_x; q.b_y = q.a_y; q.b_z = q.a_z; q.b_w = q.a_w;
                end
                pending_pairs.push_back(q);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_quats.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
